// File: hdl/jesc_pkg.sv
// Shared types and register codes for the Julia escape-time pixel unit.
// No dependencies; every other file in hdl/ imports this package.
package jesc_pkg;

  // Pixel coordinates as they arrive on the input channel.
  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
  } jesc_in_t;

  // One finished pixel on the result channel.
  typedef struct packed {
    logic [7:0] out_x;
    logic [7:0] out_y;
    logic [4:0] escape_count;
  } jesc_out_t;

  // Per-frame settings, as held in the configuration registers.
  typedef struct packed {
    logic [8:0]         frame_width;
    logic [8:0]         frame_height;
    logic [16:0]        step_real;
    logic [16:0]        step_imag;
    logic signed [15:0] c_real;
    logic signed [15:0] c_imag;
  } jesc_cfg_t;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_STEP_REAL    = 3'd2,
    REG_STEP_IMAG    = 3'd3,
    REG_C_REAL       = 3'd4,
    REG_C_IMAG       = 3'd5
  } jesc_reg_t;

  // Reset values of the registers.
  localparam logic [8:0]         RST_FRAME_WIDTH  = 9'd64;
  localparam logic [8:0]         RST_FRAME_HEIGHT = 9'd64;
  localparam logic [16:0]        RST_STEP_REAL    = 17'd384;
  localparam logic [16:0]        RST_STEP_IMAG    = 17'd256;
  localparam logic signed [15:0] RST_C_REAL       = -16'sd6554;
  localparam logic signed [15:0] RST_C_IMAG       = 16'sd6554;

endpackage

// File: hdl/julia_escape_time_pixel_top.sv
// Top level of the Julia escape-time pixel unit: configuration registers and the cell chain.
// Depends on jesc_pkg, jesc_start_cell and jesc_iter_cell.
//
// Usage:
//   Input: raise start with a pixel on in_data; the transfer happens at a rising edge
//   with start high and busy low. busy stays low, so a new pixel may follow every cycle.
//   Output: out_valid is high for exactly one cycle with the pixel and its escape count
//   on out_data. Results leave in the order the pixels came in.
//   Path from transfer to strobe: the start-point cell (scale, then halve and clamp), then
//   each iteration cell in turn (products, then test and update).
//   Throughput: one pixel per cycle; each iteration has its own cell, and no cell
//   in the chain can stall.
//   Configuration: APB write with setup and access cycles; register i at byte address 4*i.
//   Write registers only while no pixel is in the chain.
//   Reset: rst_n low clears every valid bit of the chain and loads the register defaults;
//   pixels in flight are dropped. The receiver cannot stall, so out_valid never waits.
module julia_escape_time_pixel_top
  import jesc_pkg::*;
#(
  parameter int MAX_ITERATIONS = 20,
  parameter int FRACTION_BITS  = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  jesc_in_t    in_data,
  output logic        out_valid,
  output jesc_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W      = FRACTION_BITS + 4;
  localparam int CLOG   = $clog2(MAX_ITERATIONS + 1);
  localparam int CW     = (CLOG > 5) ? CLOG : 5;
  localparam int LAT    = 2 + 2 * MAX_ITERATIONS;

  jesc_cfg_t cfg_r;
  jesc_reg_t cfg_idx;
  logic      cfg_wr;

  logic                valid_w [0:MAX_ITERATIONS];
  logic                done_w  [0:MAX_ITERATIONS];
  logic [CW-1:0]       count_w [0:MAX_ITERATIONS];
  jesc_in_t            tag_w   [0:MAX_ITERATIONS];
  logic signed [W-1:0] zr_w    [0:MAX_ITERATIONS];
  logic signed [W-1:0] zi_w    [0:MAX_ITERATIONS];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration registers.
  assign cfg_idx = jesc_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.step_real    <= RST_STEP_REAL;
      cfg_r.step_imag    <= RST_STEP_IMAG;
      cfg_r.c_real       <= RST_C_REAL;
      cfg_r.c_imag       <= RST_C_IMAG;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= pwdata[8:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= pwdata[8:0];
        REG_STEP_REAL:    cfg_r.step_real    <= pwdata[16:0];
        REG_STEP_IMAG:    cfg_r.step_imag    <= pwdata[16:0];
        REG_C_REAL:       cfg_r.c_real       <= pwdata[15:0];
        REG_C_IMAG:       cfg_r.c_imag       <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = {23'd0, cfg_r.frame_width};
      REG_FRAME_HEIGHT: prdata = {23'd0, cfg_r.frame_height};
      REG_STEP_REAL:    prdata = {15'd0, cfg_r.step_real};
      REG_STEP_IMAG:    prdata = {15'd0, cfg_r.step_imag};
      REG_C_REAL:       prdata = {{16{cfg_r.c_real[15]}}, cfg_r.c_real};
      REG_C_IMAG:       prdata = {{16{cfg_r.c_imag[15]}}, cfg_r.c_imag};
      default:          prdata = 32'd0;
    endcase
  end

  // Start-point cell at the head of the chain.
  jesc_start_cell #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_start (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (start & ~busy),
    .in_tag    (in_data),
    .out_valid (valid_w[0]),
    .out_tag   (tag_w[0]),
    .out_zr    (zr_w[0]),
    .out_zi    (zi_w[0])
  );

  assign done_w[0]  = 1'b0;
  assign count_w[0] = '0;

  // One iteration cell per allowed iteration.
  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_iter
    jesc_iter_cell #(
      .FRACTION_BITS(FRACTION_BITS),
      .CW           (CW)
    ) u_iter (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg_r),
      .in_valid  (valid_w[g]),
      .in_done   (done_w[g]),
      .in_count  (count_w[g]),
      .in_tag    (tag_w[g]),
      .in_zr     (zr_w[g]),
      .in_zi     (zi_w[g]),
      .out_valid (valid_w[g+1]),
      .out_done  (done_w[g+1]),
      .out_count (count_w[g+1]),
      .out_tag   (tag_w[g+1]),
      .out_zr    (zr_w[g+1]),
      .out_zi    (zi_w[g+1])
    );
  end

  // The last cell's registers drive the result channel.
  assign out_valid             = valid_w[MAX_ITERATIONS];
  assign out_data.out_x        = tag_w[MAX_ITERATIONS].pixel_x;
  assign out_data.out_y        = tag_w[MAX_ITERATIONS].pixel_y;
  assign out_data.escape_count = count_w[MAX_ITERATIONS][4:0];

`ifndef SYNTHESIS
  // Every accepted pixel comes out after the fixed chain latency.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted pixel did not reach the output on time");

  // Nothing comes out that was not accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!start || busy) |-> ##LAT !out_valid)
    else $error("result strobe without an accepted pixel");

  // The count never passes the iteration cap.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (count_w[MAX_ITERATIONS] <= CW'(MAX_ITERATIONS)))
    else $error("escape count above the iteration cap");
`endif

endmodule

// File: hdl/jesc_start_cell.sv
// First cell of the chain: maps a pixel about the frame centre to the start point z0.
// Depends on jesc_pkg for the pixel and configuration types.
module jesc_start_cell
  import jesc_pkg::*;
#(
  parameter int FRACTION_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  jesc_cfg_t                    cfg,
  input  logic                         in_valid,
  input  jesc_in_t                     in_tag,
  output logic                         out_valid,
  output jesc_in_t                     out_tag,
  output logic signed [FRACTION_BITS+3:0] out_zr,
  output logic signed [FRACTION_BITS+3:0] out_zi
);

  localparam int W  = FRACTION_BITS + 4;
  localparam int DW = 11;
  localparam int PW = DW + 18;
  localparam logic signed [PW-1:0] FX_MAX = $signed(PW'(2**(W-1) - 1));
  localparam logic signed [PW-1:0] FX_MIN = -FX_MAX - PW'(1);

  logic                 a_valid_r;
  jesc_in_t             a_tag_r;
  logic signed [PW-1:0] a_pr_r;
  logic signed [PW-1:0] a_pi_r;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [PW-1:0] hr;
  logic signed [PW-1:0] hi;
  logic signed [W-1:0]  zr_nxt;
  logic signed [W-1:0]  zi_nxt;

  // Offset from the centre, doubled so the half-pixel stays exact.
  assign dx = $signed({2'b00, in_tag.pixel_x, 1'b0}) - $signed({2'b00, cfg.frame_width});
  assign dy = $signed({2'b00, in_tag.pixel_y, 1'b0}) - $signed({2'b00, cfg.frame_height});

  // Stage A: scale by the step per pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_tag_r <= in_tag;
    a_pr_r  <= dx * $signed({1'b0, cfg.step_real});
    a_pi_r  <= dy * $signed({1'b0, cfg.step_imag});
  end

  // Stage B: halve with floor, then clamp to the fixed-point range.
  always_comb begin
    hr = a_pr_r >>> 1;
    hi = a_pi_r >>> 1;
    if (hr > FX_MAX) begin
      zr_nxt = FX_MAX[W-1:0];
    end else if (hr < FX_MIN) begin
      zr_nxt = FX_MIN[W-1:0];
    end else begin
      zr_nxt = hr[W-1:0];
    end
    if (hi > FX_MAX) begin
      zi_nxt = FX_MAX[W-1:0];
    end else if (hi < FX_MIN) begin
      zi_nxt = FX_MIN[W-1:0];
    end else begin
      zi_nxt = hi[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_tag <= a_tag_r;
    out_zr  <= zr_nxt;
    out_zi  <= zi_nxt;
  end

endmodule

// File: hdl/jesc_iter_cell.sv
// One iteration cell of the chain: tests |z|^2 against 4 and forms z*z + c.
// Depends on jesc_pkg for the pixel and configuration types.
module jesc_iter_cell
  import jesc_pkg::*;
#(
  parameter int FRACTION_BITS = 14,
  parameter int CW            = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  jesc_cfg_t                    cfg,
  input  logic                         in_valid,
  input  logic                         in_done,
  input  logic [CW-1:0]                in_count,
  input  jesc_in_t                     in_tag,
  input  logic signed [FRACTION_BITS+3:0] in_zr,
  input  logic signed [FRACTION_BITS+3:0] in_zi,
  output logic                         out_valid,
  output logic                         out_done,
  output logic [CW-1:0]                out_count,
  output jesc_in_t                     out_tag,
  output logic signed [FRACTION_BITS+3:0] out_zr,
  output logic signed [FRACTION_BITS+3:0] out_zi
);

  localparam int W  = FRACTION_BITS + 4;
  localparam int PW = 2 * W;
  localparam logic [PW:0] FOUR = (PW+1)'(1) << (2 * FRACTION_BITS + 2);
  localparam logic signed [PW:0] FX_MAX = $signed((PW+1)'(2**(W-1) - 1));
  localparam logic signed [PW:0] FX_MIN = -FX_MAX - (PW+1)'(1);

  logic                 a_valid_r;
  logic                 a_done_r;
  logic [CW-1:0]        a_count_r;
  jesc_in_t             a_tag_r;
  logic signed [PW-1:0] a_rr_r;
  logic signed [PW-1:0] a_ii_r;
  logic signed [PW-1:0] a_ri_r;

  logic [PW:0]          mag2;
  logic                 escape;
  logic signed [PW:0]   diff;
  logic signed [PW:0]   re_s;
  logic signed [PW:0]   im_s;
  logic signed [W-1:0]  zr_nxt;
  logic signed [W-1:0]  zi_nxt;
  logic                 done_nxt;
  logic [CW-1:0]        count_nxt;

  // Stage A: the three products at full width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_done_r  <= in_done;
    a_count_r <= in_count;
    a_tag_r   <= in_tag;
    a_rr_r    <= in_zr * in_zr;
    a_ii_r    <= in_zi * in_zi;
    a_ri_r    <= in_zr * in_zi;
  end

  // Stage B: escape test, then the new z with floor shift and clamp.
  always_comb begin
    mag2   = {a_rr_r[PW-1], a_rr_r} + {a_ii_r[PW-1], a_ii_r};
    escape = mag2 >= FOUR;
    diff   = {a_rr_r[PW-1], a_rr_r} - {a_ii_r[PW-1], a_ii_r};
    re_s   = (diff >>> FRACTION_BITS)
           + $signed({{(PW-15){cfg.c_real[15]}}, cfg.c_real});
    // Doubling zr*zi and shifting by F is a shift by F-1.
    im_s   = ($signed({a_ri_r[PW-1], a_ri_r}) >>> (FRACTION_BITS - 1))
           + $signed({{(PW-15){cfg.c_imag[15]}}, cfg.c_imag});
    if (re_s > FX_MAX) begin
      zr_nxt = FX_MAX[W-1:0];
    end else if (re_s < FX_MIN) begin
      zr_nxt = FX_MIN[W-1:0];
    end else begin
      zr_nxt = re_s[W-1:0];
    end
    if (im_s > FX_MAX) begin
      zi_nxt = FX_MAX[W-1:0];
    end else if (im_s < FX_MIN) begin
      zi_nxt = FX_MIN[W-1:0];
    end else begin
      zi_nxt = im_s[W-1:0];
    end
    // A pixel that has already escaped keeps its count and done flag; its z still updates.
    done_nxt  = a_done_r | escape;
    count_nxt = done_nxt ? a_count_r : a_count_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_done  <= done_nxt;
    out_count <= count_nxt;
    out_tag   <= a_tag_r;
    out_zr    <= zr_nxt;
    out_zi    <= zi_nxt;
  end

`ifndef SYNTHESIS
  // An escaped pixel keeps its count through the cell.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_done) |-> ##2 (out_done && out_count == $past(in_count, 2)))
    else $error("escaped pixel changed count in iteration cell");

  // The count grows by at most one per cell.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> ##2 (out_valid && (out_count == $past(in_count, 2)
                      || out_count == $past(in_count, 2) + CW'(1))))
    else $error("iteration cell count stepped wrongly");

  // A count that did not grow means the pixel is marked escaped.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_done) |-> ##2 (out_done || out_count == $past(in_count, 2) + CW'(1)))
    else $error("live pixel neither escaped nor counted");
`endif

endmodule
